@@ hw/rtl/bgs_pkg.sv @@
// ----------------------------------------------------------------------------
// bgs_pkg
// Shared types and constants of the bilinear grid sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bgs_pkg;

  localparam int unsigned GRID_DIM_DEF = 256;
  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned HEIGHT_BITS  = 20;
  localparam int unsigned POS_BITS     = 16;
  localparam int unsigned CELL_BITS    = 8;
  localparam int unsigned GSIZE_BITS   = 9;
  localparam int unsigned IPOS_BITS    = POS_BITS - FRAC_BITS;
  // corner weight: product of two (FRAC_BITS+1)-bit factors, at most 2^(2*FRAC_BITS)
  localparam int unsigned WGT_BITS     = 2 * FRAC_BITS + 1;
  localparam int unsigned PROD_BITS    = HEIGHT_BITS + WGT_BITS + 1;

  localparam logic [GSIZE_BITS-1:0] GSIZE_RESET = GSIZE_BITS'(256);

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef logic signed [HEIGHT_BITS-1:0] height_t;
  typedef logic        [WGT_BITS-1:0]    weight_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;

  typedef struct packed {
    op_e                   opcode;
    logic [CELL_BITS-1:0]  cell_x;
    logic [CELL_BITS-1:0]  cell_y;
    height_t               height_value;
    logic [POS_BITS-1:0]   sample_x;
    logic [POS_BITS-1:0]   sample_y;
  } bgs_req_t;

  typedef struct packed {
    height_t sampled_height;
    logic    out_of_range;
  } bgs_rsp_t;

  // sample control handed from the address stage to the blend pipeline
  typedef struct packed {
    logic    valid;
    logic    oor;
    weight_t w00;
    weight_t w10;
    weight_t w01;
    weight_t w11;
  } bgs_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/bgs_mem.sv @@
// ----------------------------------------------------------------------------
// bgs_mem
// Height store: one read/write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bgs_mem #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 20
) (
  input  wire logic          clk_i,
  input  wire logic          we_a_i,
  input  wire logic          re_a_i,
  input  wire logic [AW-1:0] addr_a_i,
  input  wire logic [DW-1:0] wdata_a_i,
  output logic      [DW-1:0] rdata_a_o,
  input  wire logic          re_b_i,
  input  wire logic [AW-1:0] addr_b_i,
  output logic      [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_a_i) begin
      mem_q[addr_a_i] <= wdata_a_i;
    end else if (re_a_i) begin
      rdata_a_o <= mem_q[addr_a_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_b_i) begin
      rdata_b_o <= mem_q[addr_b_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bgs_blend.sv @@
// ----------------------------------------------------------------------------
// bgs_blend
// Weighted sum of the four corners, rounding and saturation, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bgs_blend import bgs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire bgs_ctl_t ctl_i,
  input  wire height_t  rd_a_i,
  input  wire height_t  rd_b_i,
  output logic          valid_o,
  output bgs_rsp_t      rsp_o
);

  localparam prod_t HALF = prod_t'(1) <<< (2 * FRAC_BITS - 1);
  localparam prod_t HMAX = prod_t'({1'b0, {(HEIGHT_BITS-1){1'b1}}});
  localparam prod_t HMIN = ~HMAX;

  // first product stage: lower row is on the read ports
  logic    v2_q, oor2_q;
  weight_t w01_q, w11_q;
  prod_t   m0_q, m1_q;
  // second product stage: upper row is on the read ports
  logic    v3_q, oor3_q;
  prod_t   s01_q, m2_q, m3_q;
  logic    valid_q;
  bgs_rsp_t rsp_q;

  prod_t   m0_d, m1_d, m2_d, m3_d;
  prod_t   sum, rnd, clamped;

  always_comb begin
    m0_d = prod_t'(rd_a_i) * prod_t'($signed({1'b0, ctl_i.w00}));
    m1_d = prod_t'(rd_b_i) * prod_t'($signed({1'b0, ctl_i.w10}));
    m2_d = prod_t'(rd_a_i) * prod_t'($signed({1'b0, w01_q}));
    m3_d = prod_t'(rd_b_i) * prod_t'($signed({1'b0, w11_q}));
  end

  always_comb begin
    sum = s01_q + m2_q + m3_q + HALF;
    rnd = sum >>> (2 * FRAC_BITS);
    if (rnd > HMAX) begin
      clamped = HMAX;
    end else if (rnd < HMIN) begin
      clamped = HMIN;
    end else begin
      clamped = rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      v2_q    <= ctl_i.valid;
      v3_q    <= v2_q;
      valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    oor2_q <= ctl_i.oor;
    w01_q  <= ctl_i.w01;
    w11_q  <= ctl_i.w11;
    m0_q   <= m0_d;
    m1_q   <= m1_d;
    oor3_q <= oor2_q;
    s01_q  <= m0_q + m1_q;
    m2_q   <= m2_d;
    m3_q   <= m3_d;
    if (oor3_q) begin
      rsp_q.sampled_height <= '0;
      rsp_q.out_of_range   <= 1'b1;
    end else begin
      rsp_q.sampled_height <= height_t'(clamped);
      rsp_q.out_of_range   <= 1'b0;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

@@ hw/rtl/bilinear_grid_sampler.sv @@
// ----------------------------------------------------------------------------
// bilinear_grid_sampler
// Grid of fixed-point heights with bilinear sampling at Q8.8 positions.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a transaction by raising start_i with req_i while busy_o is low.
//   A write transaction stores req_i.height_value at (cell_x, cell_y) and
//   gives no result. A sample transaction gives exactly one result on rsp_o,
//   marked by result_valid_o for one cycle. Results come out in the order the
//   samples were accepted. A write or an out-of-range sample leaves busy_o
//   low; an in-range sample raises it, because its four corners come out of
//   the dual-port height memory two per cycle (busy_o is high while the upper
//   row is read). Pipelined: a new transaction enters while earlier samples
//   are still being blended. grid_size is written through cfg_we_i/cfg_wdata_i;
//   the user must do so only while idle, as the block does not enforce it.
//   Reset clears the pipeline and sets grid_size to 256; the height memory is
//   not cleared, so a cell must be written before it is sampled. The receiver
//   cannot stall: each result must be taken in its cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_grid_sampler import bgs_pkg::*; #(
  parameter int unsigned GRID_DIM = GRID_DIM_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire bgs_req_t              req_i,
  output logic                       busy_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [GSIZE_BITS-1:0] cfg_wdata_i,
  output logic                       result_valid_o,
  output bgs_rsp_t                   rsp_o
);

  localparam int unsigned CW = $clog2(GRID_DIM);
  localparam int unsigned AW = 2 * CW;

  logic [GSIZE_BITS-1:0] grid_q;
  logic                  busy_q, busy_d;
  logic [CW-1:0]         row1_q, xa_q, xb_q;
  bgs_ctl_t              ctl_q, ctl_d;

  logic                  accept, is_sample, oor, write_ok, rd_first;
  logic [GSIZE_BITS-1:0] eff_size, xl_inc, yd_inc;
  logic [IPOS_BITS-1:0]  xl, yd;
  logic [FRAC_BITS-1:0]  fx, fy;
  logic [FRAC_BITS:0]    ox, oy;
  logic [CW-1:0]         ya, xa, xb;

  logic                  we_a, re_a, re_b;
  logic [AW-1:0]         addr_a, addr_b;
  logic [HEIGHT_BITS-1:0] rdata_a, rdata_b;

  always_comb begin
    accept    = start_i && !busy_q;
    is_sample = (req_i.opcode == OP_SAMPLE);
    xl        = req_i.sample_x[POS_BITS-1:FRAC_BITS];
    yd        = req_i.sample_y[POS_BITS-1:FRAC_BITS];
    fx        = req_i.sample_x[FRAC_BITS-1:0];
    fy        = req_i.sample_y[FRAC_BITS-1:0];
    ox        = {1'b1, FRAC_BITS'(0)} - {1'b0, fx};
    oy        = {1'b1, FRAC_BITS'(0)} - {1'b0, fy};
    // saturate the size in use to the physical grid
    if (32'(grid_q) < GRID_DIM) begin
      eff_size = grid_q;
    end else begin
      eff_size = GSIZE_BITS'(GRID_DIM);
    end
    xl_inc    = GSIZE_BITS'(xl) + GSIZE_BITS'(1);
    yd_inc    = GSIZE_BITS'(yd) + GSIZE_BITS'(1);
    oor       = (xl_inc >= eff_size) || (yd_inc >= eff_size);
    write_ok  = (32'(req_i.cell_x) < GRID_DIM) && (32'(req_i.cell_y) < GRID_DIM);
    ya        = CW'(yd);
    xa        = CW'(xl);
    xb        = CW'(xl_inc);
    rd_first  = accept && is_sample && !oor;
    busy_d    = rd_first;
  end

  always_comb begin
    ctl_d.valid = accept && is_sample;
    ctl_d.oor   = oor;
    ctl_d.w00   = WGT_BITS'(ox) * WGT_BITS'(oy);
    ctl_d.w10   = WGT_BITS'(fx) * WGT_BITS'(oy);
    ctl_d.w01   = WGT_BITS'(ox) * WGT_BITS'(fy);
    ctl_d.w11   = WGT_BITS'(fx) * WGT_BITS'(fy);
  end

  // second read cycle owns both ports; upper row comes from the held address
  always_comb begin
    we_a = accept && !is_sample && write_ok;
    re_a = rd_first || busy_q;
    re_b = rd_first || busy_q;
    if (busy_q) begin
      addr_a = {row1_q, xa_q};
      addr_b = {row1_q, xb_q};
    end else begin
      addr_b = {ya, xb};
      if (is_sample) begin
        addr_a = {ya, xa};
      end else begin
        addr_a = {CW'(req_i.cell_y), CW'(req_i.cell_x)};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GSIZE_RESET;
      busy_q <= 1'b0;
      ctl_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        grid_q <= cfg_wdata_i;
      end
      busy_q <= busy_d;
      ctl_q  <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_first) begin
      row1_q <= CW'(yd_inc);
      xa_q   <= xa;
      xb_q   <= xb;
    end
  end

  bgs_mem #(
    .AW (AW),
    .DW (HEIGHT_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .we_a_i    (we_a),
    .re_a_i    (re_a),
    .addr_a_i  (addr_a),
    .wdata_a_i (req_i.height_value),
    .rdata_a_o (rdata_a),
    .re_b_i    (re_b),
    .addr_b_i  (addr_b),
    .rdata_b_o (rdata_b)
  );

  bgs_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_q),
    .rd_a_i  ($signed(rdata_a)),
    .rd_b_i  ($signed(rdata_b)),
    .valid_o (result_valid_o),
    .rsp_o   (rsp_o)
  );

  assign busy_o = busy_q;

endmodule

`default_nettype wire

@@ hw/rtl/bgs_checker.sv @@
// ----------------------------------------------------------------------------
// bgs_checker
// Port-level checks of the bilinear grid sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bgs_checker import bgs_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start_i,
  input wire bgs_req_t req_i,
  input wire logic     busy_o,
  input wire logic     result_valid_o,
  input wire bgs_rsp_t rsp_o
);

  logic acc_sample, acc_write;

  assign acc_sample = start_i && !busy_o && (req_i.opcode == OP_SAMPLE);
  assign acc_write  = start_i && !busy_o && (req_i.opcode == OP_WRITE);

  // every accepted sample transaction is followed by its result
  a_sample_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_sample |-> ##4 result_valid_o)
    else $error("sample transaction gave no result");

  // a write transaction yields nothing
  a_write_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_write |-> ##4 !result_valid_o)
    else $error("write transaction gave a result");

  // the second corner read never extends past one cycle
  a_busy_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held for more than one cycle");

  // out-of-range results carry a zero height
  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.out_of_range) |-> (rsp_o.sampled_height == '0))
    else $error("out-of-range result with nonzero height");

endmodule

bind bilinear_grid_sampler bgs_checker u_bgs_checker (.*);

`default_nettype wire
